// ----- hdl/tqm_pkg.sv -----
// tqm_pkg: widths, constants and shared types of the triangle quality pipeline
// no dependencies
package tqm_pkg;

  localparam int COORD_W  = 20;           // vertex coordinate, signed
  localparam int EDGE_W   = COORD_W + 1;  // coordinate difference, signed
  localparam int PROD_W   = 2 * EDGE_W;   // product of two differences, signed
  localparam int CROSS_W  = PROD_W + 1;   // cross product component, signed
  localparam int MAG_W    = PROD_W;       // cross component magnitude
  localparam int HALF_W   = MAG_W / 2;    // split point for the squaring
  localparam int M2_W     = 2 * MAG_W;    // squared cross component
  localparam int S_W      = M2_W;         // squared cross magnitude
  localparam int ESQ_W    = 43;           // squared edge length
  localparam int AREA_W   = 43;
  localparam int RATIO_W  = 24;
  localparam int NORM_W   = 16;

  localparam int RATIO_GUARD = 16;        // ratio saturates at 2^8, squared 2^16
  localparam int RATIO_SHIFT = 32;
  localparam int RATIO_QW    = 2 * RATIO_W;
  localparam int NORM_SHIFT  = 30;
  localparam int NORM_QW     = NORM_SHIFT + 1;
  localparam int NORM_SQ_W   = 2 * NORM_W;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [NORM_W-1:0]  NORM_POS_MAX = {1'b0, {(NORM_W-1){1'b1}}};

  // results of the front end, one triangle
  typedef struct packed {
    logic [2:0]           neg;
    logic                 sat;
    logic [2:0][M2_W-1:0] m2;
    logic [S_W-1:0]       s;
    logic [ESQ_W-1:0]     smax;   // longest squared edge
    logic [ESQ_W-1:0]     smin;   // shortest squared edge
  } front_t;

  // per-item flags carried alongside the long arithmetic
  typedef struct packed {
    logic [2:0] neg;
    logic       sat;
    logic       deg;
  } meta_t;

endpackage

// ----- hdl/tqm_delay.sv -----
// tqm_delay: enabled shift line that aligns side data with the long lanes
// no dependencies
module tqm_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign d_o = tap_q[N-1];

endmodule

// ----- hdl/tqm_div_pipe.sv -----
// tqm_div_pipe: pipelined restoring divider, one quotient bit per stage
// computes floor(num * 2^SHIFT / den); needs (num * 2^SHIFT) >> QW below den
module tqm_div_pipe #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int SHIFT = 1,
  parameter int QW    = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QW-1:0]    quo_o
);

  localparam int DVD_W = NUM_W + SHIFT;

  logic [DVD_W-1:0] dvd;
  logic [DEN_W-1:0] rem_s [QW+1];
  logic [DEN_W-1:0] den_s [QW+1];
  logic [QW-1:0]    ql_s  [QW+1];   // remaining dividend bits on top, quotient below

  assign dvd      = {num_i, {SHIFT{1'b0}}};
  assign rem_s[0] = DEN_W'(dvd[DVD_W-1:QW]);
  assign den_s[0] = den_i;
  assign ql_s[0]  = dvd[QW-1:0];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;

    assign t  = {rem_s[i], ql_s[i][QW-1]};
    assign ge = t >= {1'b0, den_s[i]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[i+1] <= ge ? DEN_W'(t - {1'b0, den_s[i]}) : DEN_W'(t);
        den_s[i+1] <= den_s[i];
        ql_s[i+1]  <= {ql_s[i][QW-2:0], ge};
      end
    end
  end

  assign quo_o = ql_s[QW];

endmodule

// ----- hdl/tqm_isqrt_pipe.sv -----
// tqm_isqrt_pipe: pipelined digit-by-digit integer square root, one root bit per stage
// no dependencies; IN_W must be even
module tqm_isqrt_pipe #(
  parameter int IN_W = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic [IN_W/2-1:0] root_o
);

  localparam int OW = IN_W / 2;

  logic [OW:0]     rem_s  [OW+1];
  logic [OW-1:0]   root_s [OW+1];
  logic [IN_W-1:0] rest_s [OW+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rest_s[0] = rad_i;

  for (genvar i = 0; i < OW; i++) begin : g_step
    logic [OW+2:0] t;
    logic [OW+2:0] trial;
    logic          ge;

    assign t     = {rem_s[i], rest_s[i][IN_W-1 -: 2]};
    assign trial = {1'b0, root_s[i], 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[i+1]  <= ge ? (OW+1)'(t - trial) : (OW+1)'(t);
        root_s[i+1] <= {root_s[i][OW-2:0], ge};
        rest_s[i+1] <= {rest_s[i][IN_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_s[OW];

endmodule

// ----- hdl/tqm_front.sv -----
// tqm_front: six-stage front end: edges, cross product, squared terms, edge extremes
// depends on tqm_pkg
module tqm_front (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic [2:0][2:0][tqm_pkg::COORD_W-1:0]     vtx_i,   // [vertex][axis]
  output tqm_pkg::front_t                           front_o
);

  import tqm_pkg::*;

  // stage 1: differences
  logic signed [EDGE_W-1:0] e1_q [3];
  logic signed [EDGE_W-1:0] e2_q [3];
  logic signed [EDGE_W-1:0] f_q  [3];
  // stage 2: products
  logic signed [PROD_W-1:0] cpa_q [3];
  logic signed [PROD_W-1:0] cpb_q [3];
  logic signed [PROD_W-1:0] sab_q [3];
  logic signed [PROD_W-1:0] sca_q [3];
  logic signed [PROD_W-1:0] sbc_q [3];
  // stage 3: cross product and squared edges
  logic signed [CROSS_W-1:0] cr_q [3];
  logic [ESQ_W-1:0]          esq_q [3];
  // stage 4: partial squares and extremes
  logic [2:0]               neg4_q;
  logic [MAG_W-1:0]         hh_q [3];
  logic [MAG_W-1:0]         hl_q [3];
  logic [MAG_W-1:0]         ll_q [3];
  logic [ESQ_W-1:0]         smax_q, smin_q;
  // stage 5
  logic [2:0]               neg5_q;
  logic                     sat5_q;
  logic [M2_W-1:0]          m2_5_q [3];
  logic [ESQ_W-1:0]         smax5_q, smin5_q;
  // stage 6
  front_t                   out_q;

  logic [MAG_W-1:0] mag [3];
  logic [ESQ_W-1:0] smax_d, smin_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= $signed({vtx_i[1][k][COORD_W-1], vtx_i[1][k]})
                 - $signed({vtx_i[0][k][COORD_W-1], vtx_i[0][k]});
        e2_q[k] <= $signed({vtx_i[2][k][COORD_W-1], vtx_i[2][k]})
                 - $signed({vtx_i[0][k][COORD_W-1], vtx_i[0][k]});
        f_q[k]  <= $signed({vtx_i[2][k][COORD_W-1], vtx_i[2][k]})
                 - $signed({vtx_i[1][k][COORD_W-1], vtx_i[1][k]});
        sab_q[k] <= e1_q[k] * e1_q[k];
        sca_q[k] <= e2_q[k] * e2_q[k];
        sbc_q[k] <= f_q[k] * f_q[k];
      end
    end
  end

  // cross product terms, component k uses axes k+1 and k+2
  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int A1 = (k + 1) % 3;
    localparam int A2 = (k + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cpa_q[k] <= e1_q[A1] * e2_q[A2];
        cpb_q[k] <= e1_q[A2] * e2_q[A1];
        cr_q[k]  <= $signed({cpa_q[k][PROD_W-1], cpa_q[k]})
                  - $signed({cpb_q[k][PROD_W-1], cpb_q[k]});
      end
    end

    assign mag[k] = cr_q[k][CROSS_W-1] ? MAG_W'(-cr_q[k]) : MAG_W'(cr_q[k]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      esq_q[0] <= ESQ_W'(sab_q[0][PROD_W-2:0]) + ESQ_W'(sab_q[1][PROD_W-2:0])
                + ESQ_W'(sab_q[2][PROD_W-2:0]);
      esq_q[1] <= ESQ_W'(sbc_q[0][PROD_W-2:0]) + ESQ_W'(sbc_q[1][PROD_W-2:0])
                + ESQ_W'(sbc_q[2][PROD_W-2:0]);
      esq_q[2] <= ESQ_W'(sca_q[0][PROD_W-2:0]) + ESQ_W'(sca_q[1][PROD_W-2:0])
                + ESQ_W'(sca_q[2][PROD_W-2:0]);
    end
  end

  always_comb begin
    smax_d = (esq_q[0] > esq_q[1]) ? esq_q[0] : esq_q[1];
    if (esq_q[2] > smax_d) begin
      smax_d = esq_q[2];
    end
    smin_d = (esq_q[0] < esq_q[1]) ? esq_q[0] : esq_q[1];
    if (esq_q[2] < smin_d) begin
      smin_d = esq_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        neg4_q[k] <= cr_q[k][CROSS_W-1];
        hh_q[k]   <= mag[k][MAG_W-1:HALF_W] * mag[k][MAG_W-1:HALF_W];
        hl_q[k]   <= mag[k][MAG_W-1:HALF_W] * mag[k][HALF_W-1:0];
        ll_q[k]   <= mag[k][HALF_W-1:0] * mag[k][HALF_W-1:0];
        m2_5_q[k] <= (M2_W'(hh_q[k]) << (2 * HALF_W)) + (M2_W'(hl_q[k]) << (HALF_W + 1))
                   + M2_W'(ll_q[k]);
        out_q.m2[k] <= m2_5_q[k];
      end
      smax_q  <= smax_d;
      smin_q  <= smin_d;
      smax5_q <= smax_q;
      smin5_q <= smin_q;
      neg5_q <= neg4_q;
      sat5_q <= (smin_q == '0) || ((smax_q >> RATIO_GUARD) >= smin_q);
      out_q.neg  <= neg5_q;
      out_q.sat  <= sat5_q;
      out_q.s    <= m2_5_q[0] + m2_5_q[1] + m2_5_q[2];
      out_q.smax <= smax5_q;
      out_q.smin <= smin5_q;
    end
  end

  assign front_o = out_q;

endmodule

// ----- hdl/triangle_quality_metrics.sv -----
// triangle_quality_metrics: top level of the triangle area, aspect ratio and normal pipeline
// depends on tqm_pkg, tqm_front, tqm_div_pipe, tqm_isqrt_pipe, tqm_delay
//
// Streaming pipeline that takes one triangle (three vertices, signed coordinates with
// 8 fraction bits) per transfer and returns one result per triangle, in order: area with
// 16 fraction bits (half the cross-product magnitude, floored), aspect ratio longest over
// shortest edge with 16 fraction bits (all ones when degenerate or at a ratio of 256 or
// more), the unit normal in Q1.15 truncated toward zero, and a degenerate flag. A new
// triangle is taken every clock cycle unless a finished result waits on out_ready_i. The
// depth is set by the aspect-ratio lane: a 48-stage bit-per-stage divider followed by a
// 24-stage square root, after a 6-stage front end and one output register.
// The whole pipeline advances as one: it moves whenever the output register is empty or
// being taken, so in_ready_o drops only while a finished result waits on out_ready_i.
module triangle_quality_metrics (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tqm_pkg::COORD_W-1:0]  ax_i,
  input  logic signed [tqm_pkg::COORD_W-1:0]  ay_i,
  input  logic signed [tqm_pkg::COORD_W-1:0]  az_i,
  input  logic signed [tqm_pkg::COORD_W-1:0]  bx_i,
  input  logic signed [tqm_pkg::COORD_W-1:0]  by_coord_i,
  input  logic signed [tqm_pkg::COORD_W-1:0]  bz_i,
  input  logic signed [tqm_pkg::COORD_W-1:0]  cx_i,
  input  logic signed [tqm_pkg::COORD_W-1:0]  cy_i,
  input  logic signed [tqm_pkg::COORD_W-1:0]  cz_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tqm_pkg::AREA_W-1:0]          area_o,
  output logic [tqm_pkg::RATIO_W-1:0]         aspect_ratio_o,
  output logic signed [tqm_pkg::NORM_W-1:0]   normal_x_o,
  output logic signed [tqm_pkg::NORM_W-1:0]   normal_y_o,
  output logic signed [tqm_pkg::NORM_W-1:0]   normal_z_o,
  output logic                                degenerate_o
);

  import tqm_pkg::*;

  // stage counts of each lane
  localparam int FRONT_LAT = 6;
  localparam int AREA_LAT  = S_W / 2;
  localparam int RATIO_LAT = RATIO_QW + RATIO_W;
  localparam int NORM_LAT  = NORM_QW + NORM_W;
  localparam int DEPTH     = FRONT_LAT + RATIO_LAT + 1;

  logic                               adv;        // whole pipeline moves this cycle
  logic [DEPTH-1:0]                   vld_q;      // one valid bit per stage
  logic [2:0][2:0][COORD_W-1:0]       vtx;
  front_t                             front;
  meta_t                              meta_in, meta;

  logic [S_W/2-1:0]                   area_root, area_root_dly;
  logic [RATIO_QW-1:0]                ratio_quo;
  logic [RATIO_W-1:0]                 ratio_root;
  logic [NORM_QW-1:0]                 norm_quo [3];
  logic [NORM_W-1:0]                  norm_root [3];
  logic [NORM_W-1:0]                  norm_root_dly [3];
  logic [NORM_W-1:0]                  norm_d [3];

  logic [AREA_W-1:0]                  area_d, area_q;
  logic [RATIO_W-1:0]                 ratio_d, ratio_q;
  logic [NORM_W-1:0]                  norm_q [3];
  logic                               deg_q;

  // stall only when a finished result is held and not taken
  assign adv        = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  assign vtx[0] = {az_i, ay_i, ax_i};
  assign vtx[1] = {bz_i, by_coord_i, bx_i};
  assign vtx[2] = {cz_i, cy_i, cx_i};

  tqm_front u_front (
    .clk_i   (clk_i),
    .en_i    (adv),
    .vtx_i   (vtx),
    .front_o (front)
  );

  // flags ride along with the aspect-ratio lane, the longest one
  assign meta_in.neg = front.neg;
  assign meta_in.sat = front.sat;
  assign meta_in.deg = (front.s == '0);

  tqm_delay #(.W($bits(meta_t)), .N(RATIO_LAT)) u_meta_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (meta_in),
    .d_o   (meta)
  );

  // area lane: sqrt of the squared cross magnitude
  tqm_isqrt_pipe #(.IN_W(S_W)) u_area_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (front.s),
    .root_o (area_root)
  );

  tqm_delay #(.W(S_W/2), .N(RATIO_LAT - AREA_LAT)) u_area_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (area_root),
    .d_o   (area_root_dly)
  );

  // aspect-ratio lane: sqrt(floor(2^32 * max / min)) over squared edge lengths
  tqm_div_pipe #(
    .NUM_W (ESQ_W),
    .DEN_W (ESQ_W),
    .SHIFT (RATIO_SHIFT),
    .QW    (RATIO_QW)
  ) u_ratio_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (front.smax),
    .den_i (front.smin),
    .quo_o (ratio_quo)
  );

  tqm_isqrt_pipe #(.IN_W(RATIO_QW)) u_ratio_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (ratio_quo),
    .root_o (ratio_root)
  );

  // normal lanes: sqrt(floor(2^30 * c_k^2 / |c|^2)), sign applied at the end
  for (genvar k = 0; k < 3; k++) begin : g_norm
    tqm_div_pipe #(
      .NUM_W (M2_W),
      .DEN_W (S_W),
      .SHIFT (NORM_SHIFT),
      .QW    (NORM_QW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (front.m2[k]),
      .den_i (front.s),
      .quo_o (norm_quo[k])
    );

    tqm_isqrt_pipe #(.IN_W(NORM_SQ_W)) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (NORM_SQ_W'(norm_quo[k])),
      .root_o (norm_root[k])
    );

    tqm_delay #(.W(NORM_W), .N(RATIO_LAT - NORM_LAT)) u_dly (
      .clk_i (clk_i),
      .en_i  (adv),
      .d_i   (norm_root[k]),
      .d_o   (norm_root_dly[k])
    );

    // root is at most 1.0; negative side reaches -1.0, positive side saturates
    always_comb begin
      if (meta.deg) begin
        norm_d[k] = '0;
      end else if (meta.neg[k]) begin
        norm_d[k] = NORM_W'(-{1'b0, norm_root_dly[k]});
      end else if (norm_root_dly[k][NORM_W-1]) begin
        norm_d[k] = NORM_POS_MAX;
      end else begin
        norm_d[k] = norm_root_dly[k];
      end
    end
  end

  assign area_d  = meta.deg ? '0 : AREA_W'(area_root_dly[S_W/2-1:1]);
  assign ratio_d = (meta.deg || meta.sat) ? RATIO_MAX : ratio_root;

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      area_q  <= area_d;
      ratio_q <= ratio_d;
      norm_q  <= norm_d;
      deg_q   <= meta.deg;
    end
  end

  assign out_valid_o    = vld_q[DEPTH-1];
  assign area_o         = area_q;
  assign aspect_ratio_o = ratio_q;
  assign normal_x_o     = norm_q[0];
  assign normal_y_o     = norm_q[1];
  assign normal_z_o     = norm_q[2];
  assign degenerate_o   = deg_q;

endmodule

// ----- sim/tb_triangle_quality_metrics.sv -----
// tb_triangle_quality_metrics: self-checking testbench of the triangle quality pipeline
// depends on tqm_pkg and triangle_quality_metrics; drives bursts of triangles, stalls the
// output side and compares every result against an in-bench computation of the metrics
`timescale 1ns / 100ps

module tb_triangle_quality_metrics;
  import tqm_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one triangle plus a flag that holds it back until the pipeline has drained
  typedef struct {
    coord_t v[9];
    bit     drain;
  } tri_t;

  typedef struct {
    logic [AREA_W-1:0]         area;
    logic [RATIO_W-1:0]        ratio;
    logic signed [NORM_W-1:0]  nx, ny, nz;
    logic                      deg;
  } metrics_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t crd [9];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [AREA_W-1:0] area_o;
  logic [RATIO_W-1:0] aspect_ratio_o;
  logic signed [NORM_W-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;

  tri_t     tri_q [$];
  metrics_t pending_metrics [$];
  int       errors = 0;
  bit       stim_done = 1'b0;

  initial begin
    foreach (crd[i]) crd[i] = '0;
  end

  triangle_quality_metrics DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .ax_i(crd[0]), .ay_i(crd[1]), .az_i(crd[2]),
    .bx_i(crd[3]), .by_coord_i(crd[4]), .bz_i(crd[5]),
    .cx_i(crd[6]), .cy_i(crd[7]), .cz_i(crd[8]),
    .out_valid_o, .out_ready_i, .area_o, .aspect_ratio_o,
    .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // floor of the square root, one result bit per step
  function automatic logic [127:0] floor_sqrt(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic metrics_t predict_metrics(tri_t t);
    metrics_t m;
    longint p[3], e1[3], e2[3], cr[3];
    longint d, lmax, lmin;
    longint sq[3];
    logic [127:0] s, root, q, mm;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t.v[3+i]) - longint'(t.v[i]);
      e2[i] = longint'(t.v[6+i]) - longint'(t.v[i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s = '0;
    for (int i = 0; i < 3; i++) begin
      mm = 128'(cr[i] < 0 ? -cr[i] : cr[i]);
      s += mm * mm;
    end
    m = '{default: '0};
    if (s == 0) begin
      // degenerate: zero area and normal, ratio pinned at full scale
      m.ratio = RATIO_MAX;
      m.deg = 1'b1;
      return m;
    end
    root = floor_sqrt(s) >> 1;
    m.area = (root > {AREA_W{1'b1}}) ? {AREA_W{1'b1}} : root[AREA_W-1:0];
    // squared edge lengths ab, bc, ca
    for (int k = 0; k < 3; k++) begin
      sq[k] = 0;
      for (int i = 0; i < 3; i++) begin
        d = longint'(t.v[((k+1)%3)*3+i]) - longint'(t.v[k*3+i]);
        sq[k] += d * d;
      end
    end
    lmax = sq[0]; lmin = sq[0];
    for (int k = 1; k < 3; k++) begin
      if (sq[k] > lmax) lmax = sq[k];
      if (sq[k] < lmin) lmin = sq[k];
    end
    if (lmin == 0 || (lmax >>> 16) >= lmin) begin
      m.ratio = RATIO_MAX;
    end else begin
      q = (128'(lmax) << 32) / 128'(lmin);
      root = floor_sqrt(q);
      m.ratio = (root > 128'(RATIO_MAX)) ? RATIO_MAX : root[RATIO_W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      mm = 128'(cr[i] < 0 ? -cr[i] : cr[i]);
      q = ((mm * mm) << 30) / s;
      d = longint'(floor_sqrt(q));
      if (cr[i] < 0) d = -d;
      // exactly +1.0 clips to the largest positive code
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      p[i] = d;
    end
    m.nx = p[0][NORM_W-1:0];
    m.ny = p[1][NORM_W-1:0];
    m.nz = p[2][NORM_W-1:0];
    return m;
  endfunction

  function automatic coord_t rnd_full();
    return coord_t'($urandom);
  endfunction

  // queue one triangle, optionally held back until the pipeline has drained
  task automatic push_tri(input longint a0, a1, a2, b0, b1, b2, c0, c1, c2,
                          input bit drain = 1'b0);
    tri_t t;
    t.v[0] = coord_t'(a0); t.v[1] = coord_t'(a1); t.v[2] = coord_t'(a2);
    t.v[3] = coord_t'(b0); t.v[4] = coord_t'(b1); t.v[5] = coord_t'(b2);
    t.v[6] = coord_t'(c0); t.v[7] = coord_t'(c1); t.v[8] = coord_t'(c2);
    t.drain = drain;
    tri_q.insert(tri_q.size(), t);
  endtask

  // stimulus
  initial begin
    longint mx, mn, o[3], r;
    int kind;
    tri_t t;
    mx = 524287; mn = -524288;
    // all three vertices equal: zero cross product
    push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx);
    // duplicate vertex, otherwise spread
    push_tri(5, 6, 7, 5, 6, 7, 900, -30, 12);
    // collinear but distinct
    push_tri(0, 0, 0, 256, 256, 256, 512, 512, 512);
    // axis-aligned normals, both signs
    push_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
    push_tri(0, 0, 0, 0, 256, 0, 256, 0, 0);
    push_tri(0, 0, 0, 0, 256, 0, 0, 0, 256);
    push_tri(0, 0, 0, 0, 0, 256, 0, 256, 0);
    push_tri(0, 0, 0, 0, 0, 256, 256, 0, 0);
    push_tri(0, 0, 0, 256, 0, 0, 0, 0, 256);
    // largest triangle: extreme corners
    push_tri(mn, mn, mn, mx, mn, mx, mn, mx, mx);
    push_tri(mx, mx, mn, mn, mx, mx, mx, mn, mx);
    push_tri(mn, mn, mn, mx, mx, mn, mn, mx, mx);
    // smallest nonzero triangle
    push_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    push_tri(-1, -1, -1, 0, -1, -1, -1, 0, 0);
    // ratio just under and over 256
    push_tri(0, 0, 0, 255, 0, 0, 0, 1, 0);
    push_tri(0, 0, 0, 256, 0, 0, 0, 1, 0);
    push_tri(0, 0, 0, 300000, 0, 0, 0, 1, 0);
    push_tri(0, 0, 0, 2, 0, 0, 1, 2, 0);
    // equilateral-ish, ratio near one
    push_tri(0, 0, 0, 1000, 0, 0, 500, 866, 0, 1'b1);
    // random part
    for (int n = 0; n < 1300; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) o[i] = longint'(rnd_full());
      if (kind < 3) begin
        for (int i = 0; i < 9; i++) t.v[i] = rnd_full();
      end else if (kind < 8) begin
        // local triangle around a random origin, size from tiny to wide
        r = longint'(1) << $urandom_range(0, 18);
        for (int v = 0; v < 3; v++)
          for (int i = 0; i < 3; i++)
            t.v[v*3+i] = coord_t'(o[i] + longint'($urandom_range(0, 2*r)) - r);
      end else if (kind == 8) begin
        // third vertex takes each coordinate from the first or the second vertex
        for (int i = 0; i < 9; i++) t.v[i] = rnd_full();
        for (int i = 0; i < 3; i++) t.v[6+i] = t.v[$urandom_range(0, 1)*3+i];
      end else begin
        // collinear: c = a + k*(b - a)
        for (int i = 0; i < 3; i++) begin
          t.v[i] = coord_t'(o[i] >>> 2);
          t.v[3+i] = coord_t'((o[i] >>> 2) + $urandom_range(0, 2000) - 1000);
          t.v[6+i] = coord_t'(2 * longint'(t.v[3+i]) - longint'(t.v[i]));
        end
      end
      t.drain = (n == 650);
      tri_q.insert(tri_q.size(), t);
    end
  end

  // sender: bursts of random length, gaps between them, two drain pauses
  int  burst_left = 0;
  int  gap_left = 0;
  bit  taken = 1'b0;

  always @(posedge clk_i) begin
    taken <= 1'b0;
    if (rst_ni && in_valid_i && in_ready_o) begin
      tri_t t;
      foreach (t.v[i]) t.v[i] = crd[i];
      t.drain = 1'b0;
      pending_metrics.insert(pending_metrics.size(), predict_metrics(t));
      taken <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (tri_q.size() == 0) begin
        in_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end else if (tri_q[0].drain && pending_metrics.size() != 0) begin
        in_valid_i <= 1'b0;
      end else begin
        foreach (crd[i]) crd[i] <= tri_q[0].v[i];
        void'(tri_q.pop_front());
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // receiver: stall style is picked anew at random from four modes
  int stall_mode = 0;
  int mode_cnt = 0;
  int phase = 0;

  always @(negedge clk_i) begin
    if (mode_cnt == 0) begin
      mode_cnt = $urandom_range(50, 300);
      stall_mode = $urandom_range(0, 3);
    end
    mode_cnt--;
    phase++;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= (phase % 4 == 0);
      default: out_ready_i <= ((phase / 7) % 2 == 0);
    endcase
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_metrics.size() == 0) begin
        $display("%0t: result with nothing expected: area %0d", $time, area_o);
        errors++;
      end else begin
        metrics_t e;
        e = pending_metrics.pop_front();
        if (area_o !== e.area) begin
          $display("%0t: area expected %0d got %0d", $time, e.area, area_o);
          errors++;
        end
        if (aspect_ratio_o !== e.ratio) begin
          $display("%0t: aspect ratio expected %0d got %0d", $time, e.ratio, aspect_ratio_o);
          errors++;
        end
        if (normal_x_o !== e.nx) begin
          $display("%0t: normal x expected %0d got %0d", $time, e.nx, normal_x_o);
          errors++;
        end
        if (normal_y_o !== e.ny) begin
          $display("%0t: normal y expected %0d got %0d", $time, e.ny, normal_y_o);
          errors++;
        end
        if (normal_z_o !== e.nz) begin
          $display("%0t: normal z expected %0d got %0d", $time, e.nz, normal_z_o);
          errors++;
        end
        if (degenerate_o !== e.deg) begin
          $display("%0t: degenerate expected %0b got %0b", $time, e.deg, degenerate_o);
          errors++;
        end
      end
    end
  end

  // reset, then wait for the stream to finish and the pipeline to empty
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stim_done && pending_metrics.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_metrics.size() == 0) begin
      $display("tb_triangle_quality_metrics: clean");
    end else begin
      $display("tb_triangle_quality_metrics: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_triangle_quality_metrics: errors");
    $finish;
  end

endmodule
